[hdl/tceq_pkg.sv]
// shared types and status codes for the two class event queue
`timescale 1ns / 1ps
package tceq_pkg;
   localparam logic OP_PUBLISH = 1'b0;
   localparam logic OP_POLL    = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE = 3'd1;
   localparam logic [2:0] ST_BAD_PRIO  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   // classified command handed from front to back
   typedef struct packed {
      logic        poll;
      logic [2:0]  reject;   // ST_OK when the publish passed the checks
      logic        safety;
      logic [15:0] event_type;
      logic [31:0] stamp_ms;
      logic [3:0]  length;
      logic [63:0] payload;
   } cmd_type;
endpackage

[hdl/tceq_front.sv]
// input stage: checks a request and queues the classified command
`timescale 1ns / 1ps
module tceq_front import tceq_pkg::*; #(
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_event_type,
   input  logic [1:0]  req_priority_req,
   input  logic [31:0] req_stamp_ms,
   input  logic [3:0]  req_payload_length,
   input  logic [63:0] req_payload_bits,
   output logic        cmd_valid,
   input  logic        cmd_take,
   output cmd_type     cmd
);
   localparam logic [3:0] MAX_LEN = 4'(PAYLOAD_BYTES);
   localparam logic [63:0] PAY_MASK =
      (PAYLOAD_BYTES >= 8) ? '1 : ((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);

   // two-entry queue between front and back
   cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   cmd_type c;
   logic push, pop;

   assign req_stall = cnt_ff == 2'd2;
   assign push = req_valid & ~req_stall;
   assign cmd_valid = cnt_ff != 2'd0;
   assign pop = cmd_valid & cmd_take;
   assign cmd = q_ff[rd_ff];

   always_comb begin
      c.poll       = req_op == OP_POLL;
      c.safety     = req_priority_req[0];
      c.event_type = req_event_type;
      c.stamp_ms   = req_stamp_ms;
      c.length     = req_payload_length;
      c.payload    = req_payload_bits & PAY_MASK;
      if (req_payload_length > MAX_LEN) c.reject = ST_TOO_LARGE;
      else if (req_priority_req[1]) c.reject = ST_BAD_PRIO;
      else c.reject = ST_OK;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= c;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
   end
endmodule

[hdl/tceq_back.sv]
// slot store, two index rings and the result register
`timescale 1ns / 1ps
module tceq_back import tceq_pkg::*; #(
   parameter int SLOT_COUNT     = 8,
   parameter int RESERVED_SLOTS = 2,
   parameter int NORMAL_DEPTH   = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_take,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_got_type,
   output logic        rsp_got_priority,
   output logic [31:0] rsp_got_stamp_ms,
   output logic [3:0]  rsp_got_length,
   output logic [63:0] rsp_got_payload,
   output logic [2:0]  rsp_free_ordinary,
   output logic [1:0]  rsp_free_reserved,
   output logic [2:0]  rsp_normal_waiting,
   output logic [3:0]  rsp_safety_waiting
);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int NW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
   localparam int SCW = $clog2(SLOT_COUNT + 1);
   localparam int NCW = $clog2(NORMAL_DEPTH + 1);
   localparam logic [SCW-1:0] S_CAP = SCW'(SLOT_COUNT);
   localparam logic [NCW-1:0] N_CAP = NCW'(NORMAL_DEPTH);

   typedef enum logic [1:0] {
      S_DECIDE = 2'b01,
      S_READ   = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [SW-1:0] sring [SLOT_COUNT];
   logic [SW-1:0] nring [NORMAL_DEPTH];
   logic [SW-1:0] shead_ff, stail_ff, nsel_slot;
   logic [NW-1:0] nhead_ff, ntail_ff;
   logic [SCW-1:0] scnt_ff;
   logic [NCW-1:0] ncnt_ff;

   // slot memory: header and payload
   logic [15:0] m_type [SLOT_COUNT];
   logic        m_prio [SLOT_COUNT];
   logic [31:0] m_stamp [SLOT_COUNT];
   logic [3:0]  m_len [SLOT_COUNT];
   logic [63:0] m_pay [SLOT_COUNT];
   logic [SW-1:0] rd_slot_ff;

   logic [2:0]  st_ff;
   logic [15:0] ty_ff;
   logic        pr_ff;
   logic [31:0] sm_ff;
   logic [3:0]  ln_ff;
   logic [63:0] py_ff;
   logic        ov_ff;
   logic        zero_ff;

   logic [SW-1:0] pick;
   logic          found, push_ok, do_pub, do_pop, pop_safety, out_free;
   logic [2:0]    status_d;
   logic [SCW-1:0] free_o, free_r;

   assign out_free = ~ov_ff | ~rsp_stall;

   // lowest free slot: a safety event tries the reserved slots first, then the ordinary ones
   always_comb begin
      pick = '0;
      found = 1'b0;
      if (cmd.safety) begin
         for (int i = RESERVED_SLOTS - 1; i >= 0; i--) begin
            if (i < SLOT_COUNT && !busy_ff[i]) begin
               pick = SW'(i);
               found = 1'b1;
            end
         end
      end
      if (!found) begin
         for (int i = SLOT_COUNT - 1; i >= RESERVED_SLOTS; i--) begin
            if (!busy_ff[i]) begin
               pick = SW'(i);
               found = 1'b1;
            end
         end
      end
   end

   always_comb begin
      push_ok = cmd.safety ? (scnt_ff < S_CAP) : (ncnt_ff < N_CAP);
      pop_safety = scnt_ff != '0;
      nsel_slot = pop_safety ? sring[shead_ff] : nring[nhead_ff];
      do_pub = 1'b0;
      do_pop = 1'b0;
      if (cmd.poll) begin
         do_pop = pop_safety | (ncnt_ff != '0);
         status_d = do_pop ? ST_OK : ST_EMPTY;
      end else if (cmd.reject != ST_OK) begin
         status_d = cmd.reject;
      end else if (!found || !push_ok) begin
         status_d = ST_FULL;
      end else begin
         status_d = ST_OK;
         do_pub = 1'b1;
      end
   end

   wire fire = (state_ff == S_DECIDE) & cmd_valid;
   assign cmd_take = fire;

   always_comb begin
      busy_in = busy_ff;
      if (fire && do_pub) busy_in[pick] = 1'b1;
      if (fire && do_pop) busy_in[nsel_slot] = 1'b0;
      unique case (state_ff)
         S_DECIDE: state_in = fire ? S_READ : S_DECIDE;
         S_READ:   state_in = out_free ? S_DECIDE : S_READ;
         default:  state_in = S_DECIDE;
      endcase
   end

   always_comb begin
      free_o = '0;
      free_r = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!busy_ff[i]) begin
            if (i < RESERVED_SLOTS) free_r = free_r + 1'b1;
            else free_o = free_o + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && do_pub) begin
         m_type[pick]  <= cmd.event_type;
         m_prio[pick]  <= cmd.safety;
         m_stamp[pick] <= cmd.stamp_ms;
         m_len[pick]   <= cmd.length;
         m_pay[pick]   <= cmd.payload;
         if (cmd.safety) sring[stail_ff] <= pick;
         else nring[ntail_ff] <= pick;
      end
      if (fire) begin
         rd_slot_ff <= nsel_slot;
         st_ff      <= status_d;
         zero_ff    <= ~do_pop;
      end
      if (state_ff == S_READ && out_free) begin
         ty_ff <= zero_ff ? '0 : m_type[rd_slot_ff];
         pr_ff <= zero_ff ? '0 : m_prio[rd_slot_ff];
         sm_ff <= zero_ff ? '0 : m_stamp[rd_slot_ff];
         ln_ff <= zero_ff ? '0 : m_len[rd_slot_ff];
         py_ff <= zero_ff ? '0 : m_pay[rd_slot_ff];
         rsp_status <= st_ff;
         rsp_free_ordinary  <= 3'(free_o);
         rsp_free_reserved  <= 2'(free_r);
         rsp_normal_waiting <= 3'(ncnt_ff);
         rsp_safety_waiting <= 4'(scnt_ff);
      end
      if (reset) begin
         state_ff <= S_DECIDE;
         busy_ff  <= '0;
         shead_ff <= '0;
         stail_ff <= '0;
         nhead_ff <= '0;
         ntail_ff <= '0;
         scnt_ff  <= '0;
         ncnt_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         if (state_ff == S_READ && out_free) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
         if (fire && do_pub) begin
            if (cmd.safety) begin
               stail_ff <= (stail_ff == SW'(SLOT_COUNT - 1)) ? '0 : stail_ff + 1'b1;
               scnt_ff  <= scnt_ff + 1'b1;
            end else begin
               ntail_ff <= (ntail_ff == NW'(NORMAL_DEPTH - 1)) ? '0 : ntail_ff + 1'b1;
               ncnt_ff  <= ncnt_ff + 1'b1;
            end
         end
         if (fire && do_pop) begin
            if (pop_safety) begin
               shead_ff <= (shead_ff == SW'(SLOT_COUNT - 1)) ? '0 : shead_ff + 1'b1;
               scnt_ff  <= scnt_ff - 1'b1;
            end else begin
               nhead_ff <= (nhead_ff == NW'(NORMAL_DEPTH - 1)) ? '0 : nhead_ff + 1'b1;
               ncnt_ff  <= ncnt_ff - 1'b1;
            end
         end
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_got_type     = ty_ff;
   assign rsp_got_priority = pr_ff;
   assign rsp_got_stamp_ms = sm_ff;
   assign rsp_got_length   = ln_ff;
   assign rsp_got_payload  = py_ff;
endmodule

[hdl/two_class_event_queue_core.sv]
// top level of the two class event queue
`timescale 1ns / 1ps
// Strict priority event queue with reserved safety slots. In the back end a
// request first passes S_DECIDE, which picks a slot and updates the rings,
// and then S_READ, which reads the slot memory into the result register. A
// two-entry command queue lets the front accept while a result waits; the
// back end takes no new request until the last result is registered.
module two_class_event_queue_core import tceq_pkg::*; #(
   parameter int SLOT_COUNT     = 8,
   parameter int RESERVED_SLOTS = 2,
   parameter int NORMAL_DEPTH   = 6,
   parameter int PAYLOAD_BYTES  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_event_type,
   input  logic [1:0]  req_priority_req,
   input  logic [31:0] req_stamp_ms,
   input  logic [3:0]  req_payload_length,
   input  logic [63:0] req_payload_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_got_type,
   output logic        rsp_got_priority,
   output logic [31:0] rsp_got_stamp_ms,
   output logic [3:0]  rsp_got_length,
   output logic [63:0] rsp_got_payload,
   output logic [2:0]  rsp_free_ordinary,
   output logic [1:0]  rsp_free_reserved,
   output logic [2:0]  rsp_normal_waiting,
   output logic [3:0]  rsp_safety_waiting
);
   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   tceq_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_event_type,
      .req_priority_req, .req_stamp_ms, .req_payload_length, .req_payload_bits,
      .cmd_valid, .cmd_take, .cmd
   );

   tceq_back #(
      .SLOT_COUNT(SLOT_COUNT), .RESERVED_SLOTS(RESERVED_SLOTS),
      .NORMAL_DEPTH(NORMAL_DEPTH)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_got_type, .rsp_got_priority, .rsp_got_stamp_ms,
      .rsp_got_length, .rsp_got_payload, .rsp_free_ordinary, .rsp_free_reserved,
      .rsp_normal_waiting, .rsp_safety_waiting
   );
endmodule
